// ----- rtl/pwmpdc_pkg.sv -----
// Shared types and constants for the PWM period/duty calculator.
package pwmpdc_pkg;

  localparam int unsigned DIV_W   = 32;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned NCODES  = 8;
  localparam int unsigned CH_W    = 3;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [DIV_W-1:0] CLOCK_HZ_RST = 32'd48000000;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_CLOCK_HZ    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_CHANNEL_SEL = 2'd1;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_CH    = 2'd1,
    STAT_ZERO_FREQ = 2'd2
  } status_t;

  // data that rides along the divider untouched
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    status_t           status;
  } side_t;

endpackage

// ----- rtl/pwmpdc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with elastic flow control.
module pwmpdc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pwmpdc_pkg::DIV_W-1:0]      in_num,
  input  logic [pwmpdc_pkg::DIV_W-1:0]      in_den,
  input  pwmpdc_pkg::side_t                 in_side,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pwmpdc_pkg::DIV_W-1:0]      out_quo,
  output pwmpdc_pkg::side_t                 out_side
);

  localparam int unsigned N = pwmpdc_pkg::DIV_W;

  logic [N-1:0]      v_r;
  logic [N-1:0]      rem_r  [N];
  logic [N-1:0]      num_r  [N];
  logic [N-1:0]      den_r  [N];
  logic [N-1:0]      quo_r  [N];
  pwmpdc_pkg::side_t side_r [N];

  logic [N-1:0]      v_in;
  logic [N-1:0]      rem_in [N];
  logic [N-1:0]      num_in [N];
  logic [N-1:0]      den_in [N];
  logic [N-1:0]      quo_in [N];
  pwmpdc_pkg::side_t side_in [N];

  logic [N-1:0]      rem_nxt [N];
  logic [N-1:0]      quo_nxt [N];
  logic [N:0]        rdy;

  assign rdy[N] = out_ready;

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int unsigned BIT = N - 1 - s;

    if (s == 0) begin : g_first
      assign v_in[s]    = in_valid;
      assign rem_in[s]  = '0;
      assign num_in[s]  = in_num;
      assign den_in[s]  = in_den;
      assign quo_in[s]  = '0;
      assign side_in[s] = in_side;
    end else begin : g_next
      assign v_in[s]    = v_r[s-1];
      assign rem_in[s]  = rem_r[s-1];
      assign num_in[s]  = num_r[s-1];
      assign den_in[s]  = den_r[s-1];
      assign quo_in[s]  = quo_r[s-1];
      assign side_in[s] = side_r[s-1];
    end

    // stage holds if full and the next one cannot take it
    assign rdy[s] = !v_r[s] || rdy[s+1];

    logic [N:0] trial;
    logic [N:0] diff;
    always_comb begin
      trial = {rem_in[s], num_in[s][BIT]};
      diff  = trial - {1'b0, den_in[s]};
      quo_nxt[s] = quo_in[s];
      if (trial >= {1'b0, den_in[s]}) begin
        rem_nxt[s]      = diff[N-1:0];
        quo_nxt[s][BIT] = 1'b1;
      end else begin
        rem_nxt[s] = trial[N-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        rem_r[s]  <= rem_nxt[s];
        num_r[s]  <= num_in[s];
        den_r[s]  <= den_in[s];
        quo_r[s]  <= quo_nxt[s];
        side_r[s] <= side_in[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[N-1];
  assign out_quo   = quo_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// ----- rtl/pwm_period_duty_calculator_core.sv -----
// Top level: PWM prescaler, period and compare calculator behind valid/ready channels.
//
// Each transfer on the input channel (freq_hz, duty_frac) produces exactly one
// result transfer (prescale_code, period_count, compare_count, status). The
// quotient q = clock_hz / freq_hz comes from a 32-stage pipelined restoring
// divider (one quotient bit per stage); three more stages pick the prescaler,
// form and clamp the period, multiply by the duty and round. An item passes 35
// registers, the first loaded at the input transfer edge and the last driving
// out_valid and the result outputs. A new item is taken every cycle while the
// pipeline moves. A stage holds only while it is full and the stage after it is
// stalled, so empty slots fill up behind a stalled output and the input keeps
// accepting until the whole pipeline is full. The prescaler
// exponent is the smallest c in 0..7 with q <= MAX_PERIOD * 2^c (else 7), and
// the period is q >> c clamped to 1..MAX_PERIOD, which equals
// (clock_hz >> c) / freq_hz. Status 2 flags a zero frequency, status 1 a
// channel_sel at or above NUM_CHANNELS; on either error all counts are zero.
// Configuration: index 0 clock_hz (reset 48000000), index 1 channel_sel
// (reset 0); other indexes are ignored. cfg_ready is always high; write it
// only while no item is in flight.
module pwm_period_duty_calculator_core #(
  parameter int unsigned MAX_PERIOD   = 65535,
  parameter int unsigned NUM_CHANNELS = 6
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [pwmpdc_pkg::DIV_W-1:0]       in_freq_hz,
  input  logic [pwmpdc_pkg::DUTY_W-1:0]      in_duty_frac,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pwmpdc_pkg::CODE_W-1:0]      out_prescale_code,
  output logic [pwmpdc_pkg::CNT_W-1:0]       out_period_count,
  output logic [pwmpdc_pkg::CNT_W-1:0]       out_compare_count,
  output logic [1:0]                         out_status,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pwmpdc_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [pwmpdc_pkg::DIV_W-1:0]       cfg_data
);

  localparam int unsigned DW = pwmpdc_pkg::DIV_W;
  localparam int unsigned CW = pwmpdc_pkg::CNT_W;
  localparam int unsigned PW = 2 * CW;
  localparam logic [DW-1:0] MAX_P_W = DW'(MAX_PERIOD);
  localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (pwmpdc_pkg::DUTY_W - 1);

  // ---------------- configuration registers ----------------
  logic [DW-1:0]                 clock_hz_r;
  logic [pwmpdc_pkg::CH_W-1:0]   channel_sel_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r    <= pwmpdc_pkg::CLOCK_HZ_RST;
      channel_sel_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pwmpdc_pkg::CFG_CLOCK_HZ:    clock_hz_r    <= cfg_data;
        pwmpdc_pkg::CFG_CHANNEL_SEL: channel_sel_r <= cfg_data[pwmpdc_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- error classification at entry ----------------
  pwmpdc_pkg::side_t in_side;
  always_comb begin
    in_side.duty = in_duty_frac;
    // zero frequency wins over a bad channel
    if (in_freq_hz == '0) begin
      in_side.status = pwmpdc_pkg::STAT_ZERO_FREQ;
    end else if ({1'b0, channel_sel_r} >= (pwmpdc_pkg::CH_W + 1)'(NUM_CHANNELS)) begin
      in_side.status = pwmpdc_pkg::STAT_BAD_CH;
    end else begin
      in_side.status = pwmpdc_pkg::STAT_OK;
    end
  end

  // ---------------- quotient: clock_hz / freq_hz ----------------
  logic              div_valid;
  logic [DW-1:0]     div_quo;
  pwmpdc_pkg::side_t div_side;
  logic              rdy_a;

  pwmpdc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_num    (clock_hz_r),
    .in_den    (in_freq_hz),
    .in_side   (in_side),
    .out_valid (div_valid),
    .out_ready (rdy_a),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  // ---------------- stage A: prescaler pick, period clamp ----------------
  logic                          a_v_r;
  logic [pwmpdc_pkg::CODE_W-1:0] a_code_r,   a_code_nxt;
  logic [CW-1:0]                 a_period_r, a_period_nxt;
  logic [pwmpdc_pkg::DUTY_W-1:0] a_duty_r;
  pwmpdc_pkg::status_t           a_status_r;

  logic [pwmpdc_pkg::NCODES-1:0] fits;
  logic [DW-1:0]                 shifted;

  always_comb begin
    // fits[c]: q <= MAX_PERIOD * 2^c, i.e. ceil(q / MAX_PERIOD) <= 2^c
    for (int c = 0; c < pwmpdc_pkg::NCODES; c++) begin
      fits[c] = (div_quo <= (MAX_P_W << c));
    end
    a_code_nxt = pwmpdc_pkg::CODE_W'(pwmpdc_pkg::NCODES - 1);
    for (int c = pwmpdc_pkg::NCODES - 2; c >= 0; c--) begin
      if (fits[c]) begin
        a_code_nxt = pwmpdc_pkg::CODE_W'(c);
      end
    end
    shifted = div_quo >> a_code_nxt;
    priority if (shifted == '0) begin
      a_period_nxt = CW'(1);
    end else if (shifted > MAX_P_W) begin
      a_period_nxt = CW'(MAX_PERIOD);
    end else begin
      a_period_nxt = shifted[CW-1:0];
    end
    if (div_side.status != pwmpdc_pkg::STAT_OK) begin
      a_code_nxt   = '0;
      a_period_nxt = '0;
    end
  end

  // ---------------- stage B: duty multiply ----------------
  logic                          b_v_r;
  logic [pwmpdc_pkg::CODE_W-1:0] b_code_r;
  logic [CW-1:0]                 b_period_r;
  logic [PW-1:0]                 b_prod_r;
  pwmpdc_pkg::status_t           b_status_r;
  logic                          rdy_b;

  // ---------------- output register: round and shift ----------------
  logic                          o_v_r;
  logic [pwmpdc_pkg::CODE_W-1:0] o_code_r;
  logic [CW-1:0]                 o_period_r;
  logic [CW-1:0]                 o_compare_r;
  pwmpdc_pkg::status_t           o_status_r;
  logic                          rdy_o;
  logic [PW:0]                   rounded;

  // a stage loads when empty or when its content moves on
  assign rdy_o = !o_v_r || out_ready;
  assign rdy_b = !b_v_r || rdy_o;
  assign rdy_a = !a_v_r || rdy_b;

  assign rounded = {1'b0, b_prod_r} + {1'b0, ROUND_HALF};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (rdy_a) a_v_r <= div_valid;
      if (rdy_b) b_v_r <= a_v_r;
      if (rdy_o) o_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_code_r   <= a_code_nxt;
      a_period_r <= a_period_nxt;
      a_duty_r   <= div_side.duty;
      a_status_r <= div_side.status;
    end
    if (rdy_b) begin
      b_code_r   <= a_code_r;
      b_period_r <= a_period_r;
      b_prod_r   <= PW'(a_duty_r) * PW'(a_period_r);
      b_status_r <= a_status_r;
    end
    if (rdy_o) begin
      o_code_r    <= b_code_r;
      o_period_r  <= b_period_r;
      o_compare_r <= rounded[PW-1:pwmpdc_pkg::DUTY_W];
      o_status_r  <= b_status_r;
    end
  end

  assign out_valid         = o_v_r;
  assign out_prescale_code = o_code_r;
  assign out_period_count  = o_period_r;
  assign out_compare_count = o_compare_r;
  assign out_status        = o_status_r;

endmodule
